FILE: design/sndo_pkg.sv
// ----------------------------------------------------------------------------
// sndo_pkg: shared types and constants of the strided index odometer
// Sizes, operation and status codes, register indexes and the structs that
// travel between the sequencer and the dimension store.
// ----------------------------------------------------------------------------
package sndo_pkg;

    localparam int MAX_DIMS   = 8;
    localparam int COORD_BITS = 32;
    localparam int DIM_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int POS_W      = COORD_BITS + 1;
    localparam int HALF_W     = 32;
    localparam int OFF_W      = 2 * HALF_W;
    localparam int EXT_W      = 32;
    localparam int FIELD_W    = 32;
    localparam int RANK_W     = 4;
    localparam int IDX_IN_W   = 3;

    // operation codes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_STEP    = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DONE = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    // configuration register indexes
    localparam logic CFG_RANK = 1'b0;
    localparam logic CFG_FAST = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [DIM_W-1:0]      dim_idx_t;
    typedef logic [EXT_W-1:0]      ext_t;

    typedef struct packed {
        logic     en;
        dim_idx_t idx;
        coord_t   start;
        coord_t   stop;
        coord_t   stride;
        ext_t     extent;
    } dim_wr_t;

    typedef struct packed {
        logic     en;
        dim_idx_t idx;
        pos_t     value;
        logic     restart;
        dim_idx_t rank_m1;
    } pos_wr_t;

    typedef struct packed {
        coord_t start;
        coord_t stop;
        coord_t stride;
        ext_t   extent;
        pos_t   pos;
        pos_t   pos0;
        coord_t stop0;
    } dim_rd_t;

endpackage

FILE: design/sndo_mult.sv
// ----------------------------------------------------------------------------
// sndo_mult: shared registered multiplier
// One 32 x 32 multiply per cycle, product registered for the next step.
// ----------------------------------------------------------------------------
module sndo_mult
(
    input  logic                         clk,
    input  logic [sndo_pkg::HALF_W-1:0]  a,
    input  logic [sndo_pkg::EXT_W-1:0]   b,
    output logic [sndo_pkg::OFF_W-1:0]   prod
);

    logic [sndo_pkg::OFF_W-1:0] prod_reg;
    logic [sndo_pkg::OFF_W-1:0] prod_next;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: design/sndo_dim_store.sv
// ----------------------------------------------------------------------------
// sndo_dim_store: per-dimension descriptors and positions
// Descriptor words hold until loaded; positions clear on reset, restart
// from their starts, and take one write per cycle while advancing.
// ----------------------------------------------------------------------------
module sndo_dim_store
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sndo_pkg::dim_wr_t        dim_wr,
    input  sndo_pkg::pos_wr_t        pos_wr,
    input  sndo_pkg::dim_idx_t       rd_idx,
    output sndo_pkg::dim_rd_t        rd
);

    sndo_pkg::coord_t start_reg  [sndo_pkg::MAX_DIMS];
    sndo_pkg::coord_t stop_reg   [sndo_pkg::MAX_DIMS];
    sndo_pkg::coord_t stride_reg [sndo_pkg::MAX_DIMS];
    sndo_pkg::ext_t   extent_reg [sndo_pkg::MAX_DIMS];
    sndo_pkg::pos_t   pos_reg    [sndo_pkg::MAX_DIMS];

    always_ff @(posedge clk)
    begin
        if (dim_wr.en)
        begin
            start_reg[dim_wr.idx]  <= dim_wr.start;
            stop_reg[dim_wr.idx]   <= dim_wr.stop;
            stride_reg[dim_wr.idx] <= dim_wr.stride;
            extent_reg[dim_wr.idx] <= dim_wr.extent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < sndo_pkg::MAX_DIMS; d++)
            begin
                pos_reg[d] <= '0;
            end
        end
        else if (pos_wr.restart)
        begin
            for (int d = 0; d < sndo_pkg::MAX_DIMS; d++)
            begin
                if (sndo_pkg::DIM_W'(d) <= pos_wr.rank_m1)
                begin
                    pos_reg[d] <= sndo_pkg::POS_W'(start_reg[d]);
                end
            end
        end
        else if (pos_wr.en)
        begin
            pos_reg[pos_wr.idx] <= pos_wr.value;
        end
    end

    always_comb
    begin
        rd.start  = start_reg[rd_idx];
        rd.stop   = stop_reg[rd_idx];
        rd.stride = stride_reg[rd_idx];
        rd.extent = extent_reg[rd_idx];
        rd.pos    = pos_reg[rd_idx];
        rd.pos0   = pos_reg[0];
        rd.stop0  = stop_reg[0];
    end

endmodule

FILE: design/strided_nd_index_odometer.sv
// ----------------------------------------------------------------------------
// strided_nd_index_odometer: N-dimensional strided hyperslab odometer
// Loads per-dimension descriptors, restarts positions, and on each step
// reports the row-major offset and last-dimension run, then advances.
// ----------------------------------------------------------------------------
// One word in gives one word out. Load, restart and unused operations are
// accepted, then their result goes into the output register; so does a
// step that finds the iteration finished. A step with a position left
// builds the offset over the active rank (1..8) by Horner's rule with one
// shared 32 x 32 multiplier, each dimension in turn passing through a low
// half product, a high half product and an accumulate step; the carry then
// visits one dimension per cycle from the last towards dimension 0, as far
// as it walks, before the result goes out. The input side is not ready
// while an item is in work or while the result waits for the output
// register to drain. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module strided_nd_index_odometer
(
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // dim_index[2:0], first_coord[34:3],
                                   // end_coord[66:35], step_size[98:67],
                                   // extent[130:99], zero fill [135:131]
    input  logic [1:0]   s_tuser,  // operation[1:0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // linear_offset[63:0], run_length[95:64]
    output logic [2:0]   m_tuser,  // status[1:0], more[2]
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [3:0]   cfg_data
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADD,
        ST_ADV,
        ST_EMIT
    } state_t;

    // unpacked input word
    logic [1:0]                         operation;
    logic [sndo_pkg::IDX_IN_W-1:0]      dim_index;
    logic [sndo_pkg::FIELD_W-1:0]       first_coord;
    logic [sndo_pkg::FIELD_W-1:0]       end_coord;
    logic [sndo_pkg::FIELD_W-1:0]       step_size;
    logic [sndo_pkg::FIELD_W-1:0]       extent;

    state_t                             state_reg;
    sndo_pkg::dim_idx_t                 cursor_reg;
    logic [sndo_pkg::RANK_W-1:0]        active_rank_reg;
    logic                               fast_reg;
    logic [1:0]                         status_reg;
    logic                               more_reg;
    logic [sndo_pkg::OFF_W-1:0]         acc_reg;
    logic [sndo_pkg::OFF_W-1:0]         tmp_reg;
    logic [sndo_pkg::FIELD_W-1:0]       run_reg;

    logic                               m_tvalid_reg;
    logic [1:0]                         out_status_reg;
    logic                               out_more_reg;
    logic [sndo_pkg::OFF_W-1:0]         out_offset_reg;
    logic [sndo_pkg::FIELD_W-1:0]       out_run_reg;

    logic                               accept;
    logic                               desc_bad;
    logic                               idx_in_range;
    sndo_pkg::dim_idx_t                 rank_m1;
    sndo_pkg::coord_t                   ld_start;
    sndo_pkg::coord_t                   ld_stop;
    sndo_pkg::coord_t                   ld_stride;
    sndo_pkg::dim_wr_t                  dim_wr;
    sndo_pkg::pos_wr_t                  pos_wr;
    sndo_pkg::dim_rd_t                  rd;
    sndo_pkg::pos_t                     new_pos;
    logic                               adv_stop;
    logic                               adv_last;
    logic [sndo_pkg::HALF_W-1:0]        mul_a;
    logic [sndo_pkg::OFF_W-1:0]         prod;

    // word fields
    assign operation   = s_tuser;
    assign dim_index   = s_tdata[2:0];
    assign first_coord = s_tdata[34:3];
    assign end_coord   = s_tdata[66:35];
    assign step_size   = s_tdata[98:67];
    assign extent      = s_tdata[130:99];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // clamp the rank: zero counts as one, anything above the built maximum
    // counts as the maximum
    always_comb
    begin
        priority if (active_rank_reg == '0)
        begin
            rank_m1 = '0;
        end
        else if (int'(active_rank_reg) > sndo_pkg::MAX_DIMS)
        begin
            rank_m1 = sndo_pkg::DIM_W'(sndo_pkg::MAX_DIMS - 1);
        end
        else
        begin
            rank_m1 = sndo_pkg::DIM_W'(active_rank_reg - 1'b1);
        end
    end

    // descriptor check and load; a stop below start or a zero stride is
    // flagged and dropped
    always_comb
    begin
        ld_start     = sndo_pkg::COORD_BITS'(first_coord);
        ld_stop      = sndo_pkg::COORD_BITS'(end_coord);
        ld_stride    = sndo_pkg::COORD_BITS'(step_size);
        desc_bad     = (ld_stop < ld_start) || (ld_stride == '0);
        idx_in_range = (int'(dim_index) < sndo_pkg::MAX_DIMS);

        dim_wr.en     = accept && (operation == sndo_pkg::OP_LOAD) && !desc_bad
                        && idx_in_range;
        dim_wr.idx    = sndo_pkg::DIM_W'(dim_index);
        dim_wr.start  = ld_start;
        dim_wr.stop   = ld_stop;
        dim_wr.stride = ld_stride;
        dim_wr.extent = extent;
    end

    // carry step for the dimension under the cursor: the last dimension
    // jumps to its stop in fast mode; an overflowed dimension falls back to
    // its start unless it is dimension 0, which keeps the overflow
    always_comb
    begin
        adv_last = (cursor_reg == rank_m1);
        if (adv_last && fast_reg)
        begin
            new_pos = sndo_pkg::POS_W'(rd.stop);
        end
        else
        begin
            new_pos = rd.pos + sndo_pkg::POS_W'(rd.stride);
        end
        adv_stop = new_pos < sndo_pkg::POS_W'(rd.stop);

        pos_wr.en      = (state_reg == ST_ADV);
        pos_wr.idx     = cursor_reg;
        pos_wr.value   = (adv_stop || cursor_reg == '0) ? new_pos
                                                        : sndo_pkg::POS_W'(rd.start);
        pos_wr.restart = accept && (operation == sndo_pkg::OP_RESTART);
        pos_wr.rank_m1 = rank_m1;
    end

    // multiplier operand: low half of the running offset first, then high
    assign mul_a = (state_reg == ST_MUL_HI) ? acc_reg[sndo_pkg::OFF_W-1:sndo_pkg::HALF_W]
                                            : acc_reg[sndo_pkg::HALF_W-1:0];

    sndo_dim_store u_store
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .dim_wr (dim_wr),
        .pos_wr (pos_wr),
        .rd_idx (cursor_reg),
        .rd     (rd)
    );

    sndo_mult u_mult
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (rd.extent),
        .prod (prod)
    );

    // sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cursor_reg      <= '0;
            active_rank_reg <= sndo_pkg::RANK_W'(1);
            fast_reg        <= 1'b0;
            status_reg      <= sndo_pkg::STAT_OK;
            more_reg        <= 1'b0;
            acc_reg         <= '0;
            tmp_reg         <= '0;
            run_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            out_status_reg  <= sndo_pkg::STAT_OK;
            out_more_reg    <= 1'b0;
            out_offset_reg  <= '0;
            out_run_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    sndo_pkg::CFG_RANK: active_rank_reg <= cfg_data;
                    sndo_pkg::CFG_FAST: fast_reg        <= cfg_data[0];
                endcase
            end

            // drop the result once taken, unless a new one replaces it now
            if (m_tvalid_reg && m_tready && state_reg != ST_EMIT)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= sndo_pkg::STAT_OK;
                        more_reg   <= 1'b0;
                        acc_reg    <= '0;
                        run_reg    <= '0;
                        cursor_reg <= '0;
                        state_reg  <= ST_EMIT;
                        unique case (operation)
                            sndo_pkg::OP_LOAD:
                            begin
                                if (desc_bad)
                                begin
                                    status_reg <= sndo_pkg::STAT_BAD;
                                end
                            end
                            sndo_pkg::OP_STEP:
                            begin
                                if (rd.pos0 < sndo_pkg::POS_W'(rd.stop0))
                                begin
                                    more_reg  <= 1'b1;
                                    state_reg <= ST_MUL_LO;
                                end
                                else
                                begin
                                    status_reg <= sndo_pkg::STAT_DONE;
                                end
                            end
                            default:
                            begin
                                // restart acts in the store; unused code
                                // changes nothing
                            end
                        endcase
                    end
                end
                ST_MUL_LO:
                begin
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI:
                begin
                    // low product plus this dimension's position
                    tmp_reg   <= prod + sndo_pkg::OFF_W'(rd.pos);
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    acc_reg <= tmp_reg + {prod[sndo_pkg::HALF_W-1:0],
                                          {sndo_pkg::HALF_W{1'b0}}};
                    if (cursor_reg == rank_m1)
                    begin
                        if (fast_reg)
                        begin
                            run_reg <= sndo_pkg::FIELD_W'(rd.stop - rd.start);
                        end
                        else
                        begin
                            run_reg <= sndo_pkg::FIELD_W'(1);
                        end
                        state_reg <= ST_ADV;
                    end
                    else
                    begin
                        cursor_reg <= cursor_reg + 1'b1;
                        state_reg  <= ST_MUL_LO;
                    end
                end
                ST_ADV:
                begin
                    // hold here and move towards dimension 0 while carrying
                    if (adv_stop || cursor_reg == '0)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        cursor_reg <= cursor_reg - 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        out_status_reg <= status_reg;
                        out_more_reg   <= more_reg;
                        out_offset_reg <= acc_reg;
                        out_run_reg    <= run_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_run_reg, out_offset_reg};
    assign m_tuser  = {out_more_reg, out_status_reg};

endmodule

FILE: design/sndo_checker.sv
// ----------------------------------------------------------------------------
// sndo_checker: port-level checks for the strided index odometer
// Watches the stream ports; bound to the top level.
// ----------------------------------------------------------------------------
module sndo_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic [2:0]   m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

    // one word in work at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a word is in work");

    // a reported position always comes with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == sndo_pkg::STAT_OK)
    else $error("position reported with non-ok status");

    // without a position the offset and run are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[2] |-> m_tdata == '0)
    else $error("offset or run set without a position");

    // status stays within its codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1:0] == sndo_pkg::STAT_OK
                      || m_tuser[1:0] == sndo_pkg::STAT_DONE
                      || m_tuser[1:0] == sndo_pkg::STAT_BAD))
    else $error("status code out of range");

endmodule

bind strided_nd_index_odometer sndo_checker u_sndo_checker (.*);

FILE: verif/strided_nd_index_odometer_tb.sv
// ----------------------------------------------------------------------------
// strided_nd_index_odometer_tb: self-checking bench for the index odometer
// Drives descriptor loads, restarts and steps on the input stream, predicts
// every result word in a cycle-free model of the odometer and compares each
// word on the result stream, field by field, in order of arrival.
// ----------------------------------------------------------------------------
module strided_nd_index_odometer_tb;

    // the fourth operation code has no name in the package; it must be a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 40;    // margin for the slowest step to finish
    localparam int PHASE_ITEMS  = 136;
    localparam int WALK_STEPS   = 30;

    // rank setting per random phase: extremes, out-of-range values, middle
    localparam logic [3:0] RANK_PLAN [8] =
        '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd5, 4'd4};

    typedef struct packed {
        logic [1:0]  status;
        logic        more;
        logic [63:0] offset;
        logic [31:0] run;
    } report_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [95:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = 1'b0;
    logic [3:0]   cfg_data  = '0;

    // shadow of the odometer: descriptors, positions and both registers
    sndo_pkg::coord_t slab_start  [sndo_pkg::MAX_DIMS];
    sndo_pkg::coord_t slab_stop   [sndo_pkg::MAX_DIMS];
    sndo_pkg::coord_t slab_stride [sndo_pkg::MAX_DIMS];
    sndo_pkg::ext_t   slab_extent [sndo_pkg::MAX_DIMS];
    sndo_pkg::pos_t   slab_pos    [sndo_pkg::MAX_DIMS];
    logic [3:0]       rank_reg;
    logic             fast_reg;

    report_t report_q [$];         // expected result words, oldest first
    int      mismatches    = 0;
    int      items_sent    = 0;
    int      cycle_count   = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;

    strided_nd_index_odometer u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Odometer prediction
    // ------------------------------------------------------------------------

    // rank 0 behaves as 1, anything above the built maximum as the maximum
    function automatic int rank_in_use();
        if (rank_reg == 4'd0)
            return 1;
        if (int'(rank_reg) > sndo_pkg::MAX_DIMS)
            return sndo_pkg::MAX_DIMS;
        return int'(rank_reg);
    endfunction

    // Apply one accepted word to the shadow state and return its result.
    function automatic report_t compute_report(input logic [1:0]       op,
                                               input logic [2:0]       idx,
                                               input sndo_pkg::coord_t first,
                                               input sndo_pkg::coord_t last,
                                               input sndo_pkg::coord_t stride,
                                               input sndo_pkg::ext_t   ext);
        report_t rep;
        int      r;
        int      d;
        logic    carry;
        rep        = '0;
        rep.status = sndo_pkg::STAT_OK;
        r          = rank_in_use();
        case (op)
            sndo_pkg::OP_LOAD:
            begin
                // reject stop below start or a zero stride, store nothing
                if (last < first || stride == '0)
                    rep.status = sndo_pkg::STAT_BAD;
                else
                begin
                    slab_start[idx]  = first;
                    slab_stop[idx]   = last;
                    slab_stride[idx] = stride;
                    slab_extent[idx] = ext;
                end
            end
            sndo_pkg::OP_RESTART:
            begin
                for (d = 0; d < r; d++)
                    slab_pos[d] = {1'b0, slab_start[d]};
            end
            sndo_pkg::OP_STEP:
            begin
                if (slab_pos[0] < {1'b0, slab_stop[0]})
                begin
                    rep.more = 1'b1;
                    // Horner over the extents, wrapping at 64 bits
                    for (d = 0; d < r; d++)
                        rep.offset = rep.offset * 64'(slab_extent[d])
                                     + 64'(slab_pos[d]);
                    rep.run = fast_reg ? slab_stop[r-1] - slab_start[r-1] : 32'd1;
                    // carry from the last dimension towards dimension 0;
                    // dimension 0 keeps its overflowed position
                    carry = 1'b1;
                    for (d = r - 1; d >= 0 && carry; d--)
                    begin
                        if (d == r - 1 && fast_reg)
                            slab_pos[d] = {1'b0, slab_stop[d]};
                        else
                            slab_pos[d] = slab_pos[d] + {1'b0, slab_stride[d]};
                        if (slab_pos[d] < {1'b0, slab_stop[d]} || d == 0)
                            carry = 1'b0;
                        else
                            slab_pos[d] = {1'b0, slab_start[d]};
                    end
                end
                else
                    rep.status = sndo_pkg::STAT_DONE;
            end
            default: ;  // unused operation: nothing moves
        endcase
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // Stream and register drivers
    // ------------------------------------------------------------------------

    // Send one word; idle the input side first at the current sender rate.
    // Valid stays high after acceptance until the next falling edge, where
    // the next word or an idle cycle replaces it.
    task automatic send_word(input logic [1:0] op, input logic [2:0] idx,
                             input sndo_pkg::coord_t first,
                             input sndo_pkg::coord_t last,
                             input sndo_pkg::coord_t stride,
                             input sndo_pkg::ext_t ext);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, ext, stride, last, first, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        report_q.push_back(compute_report(op, idx, first, last, stride, ext));
        items_sent++;
    endtask

    // Drop valid and hold until every expected word has come back.
    task automatic drain_reports();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge clk);
    endtask

    // Register writes happen only with the block idle, so the shadow copy
    // can take the new value as soon as the write is accepted.
    task automatic write_cfg(input logic idx, input logic [3:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == sndo_pkg::CFG_RANK)
            rank_reg = value;
        else
            fast_reg = value[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_step();
        send_word(sndo_pkg::OP_STEP, 3'($urandom_range(7)), $urandom, $urandom,
                  $urandom, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Random stimulus building blocks
    // ------------------------------------------------------------------------

    // Load every active dimension with a small slab, restart and walk it to
    // the end (or a step cap), then step once more, into the finished state if the end was reached.
    // Now and then break the sequence: a rejected load, or no restart.
    task automatic walk_hyperslab();
        int               r;
        int               d;
        int               cnt;
        int               steps;
        sndo_pkg::coord_t first;
        sndo_pkg::coord_t last;
        sndo_pkg::coord_t stride;
        sndo_pkg::ext_t   ext;
        r = rank_in_use();
        for (d = 0; d < r; d++)
        begin
            if ($urandom_range(15) == 0)
            begin
                // empty dimension: start equals stop
                stride = $urandom_range(1, 8);
                first  = $urandom_range(0, 32'hFFFF_0000);
                last   = first;
            end
            else if ($urandom_range(7) == 0)
            begin
                // one position, huge stride: the step leaves the slab at once
                stride = $urandom | 32'h8000_0000;
                first  = $urandom_range(0, 32'hFFFF_0000);
                last   = first + 32'd1 + $urandom_range(0, 255);
            end
            else
            begin
                cnt    = $urandom_range(1, (r > 4) ? 2 : 3);
                stride = $urandom_range(1, 4);
                first  = ($urandom_range(3) == 0) ? $urandom_range(0, 32'hFFFF_0000)
                                                  : $urandom_range(0, 64);
                last   = first + sndo_pkg::coord_t'(cnt - 1) * stride
                         + $urandom_range(1, stride);
            end
            ext = ($urandom_range(1) == 0) ? sndo_pkg::ext_t'($urandom_range(1, 16))
                                           : sndo_pkg::ext_t'($urandom);
            send_word(sndo_pkg::OP_LOAD, 3'(d), first, last, stride, ext);
        end
        if ($urandom_range(7) == 0)
        begin
            if ($urandom_range(1) == 0)
                send_word(sndo_pkg::OP_LOAD, 3'($urandom_range(7)), 32'd10,
                          $urandom_range(0, 9), $urandom_range(1, 4), $urandom);
            else
                send_word(sndo_pkg::OP_LOAD, 3'($urandom_range(7)), 32'd0, 32'd4,
                          32'd0, $urandom);
        end
        if ($urandom_range(9) != 0)
            send_word(sndo_pkg::OP_RESTART, 3'($urandom_range(7)), $urandom, $urandom,
                      $urandom, $urandom);
        steps = 0;
        while (slab_pos[0] < {1'b0, slab_stop[0]} && steps < WALK_STEPS)
        begin
            send_step();
            steps++;
        end
        send_step();
    endtask

    // Any operation with raw field values; loads may be rejected or may
    // store a huge slab that later steps never finish.
    task automatic send_noise();
        logic [1:0]       op;
        sndo_pkg::coord_t first;
        sndo_pkg::coord_t last;
        sndo_pkg::coord_t stride;
        op     = 2'($urandom_range(3));
        first  = $urandom;
        last   = $urandom;
        stride = ($urandom_range(7) == 0) ? 32'd0 : sndo_pkg::coord_t'($urandom);
        if ($urandom_range(1) == 0 && last < first)
        begin
            last  = first;
            first = $urandom_range(0, last);
        end
        send_word(op, 3'($urandom_range(7)), first, last, stride, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every dimension gets a descriptor before anything reads one. Cover
    // all-ones and zero fields, start equal to stop, each kind of rejected
    // descriptor, the unused operation and a step from the reset positions.
    task automatic test_descriptor_loads();
        send_word(sndo_pkg::OP_LOAD, 3'd0, 32'd0, 32'd2, 32'd1, 32'd5);
        send_word(sndo_pkg::OP_LOAD, 3'd1, 32'd1, 32'd4, 32'd2, 32'd3);
        send_word(sndo_pkg::OP_LOAD, 3'd2, '1, '1, '1, '1);
        send_word(sndo_pkg::OP_LOAD, 3'd3, 32'd0, 32'd1, 32'd1, 32'd0);
        send_word(sndo_pkg::OP_LOAD, 3'd4, 32'd0, 32'd1, 32'd1, 32'd7);
        send_word(sndo_pkg::OP_LOAD, 3'd5, 32'd3, 32'd9, 32'd3, 32'd11);
        send_word(sndo_pkg::OP_LOAD, 3'd6, 32'd0, '1, 32'd1, 32'd2);
        send_word(sndo_pkg::OP_LOAD, 3'd7, 32'd0, 32'd1, 32'd1, '1);
        // stop below start, then a zero stride
        send_word(sndo_pkg::OP_LOAD, 3'd0, 32'd5, 32'd4, 32'd1, 32'd9);
        send_word(sndo_pkg::OP_LOAD, 3'd1, 32'd0, 32'd8, 32'd0, 32'd9);
        send_word(OP_UNUSED, 3'd7, '1, '1, '1, '1);
        send_step();                                             // positions from reset
    endtask

    // Rank 2: walk a 2 x 2 slab in row-major order into the finished state,
    // then repeat in fast mode where the last dimension jumps to its stop.
    task automatic test_directed_walk();
        drain_reports();
        write_cfg(sndo_pkg::CFG_RANK, 4'd2);
        write_cfg(sndo_pkg::CFG_FAST, 4'd0);
        send_word(sndo_pkg::OP_RESTART, 3'd0, '0, '0, '0, '0);
        repeat (5)
            send_step();
        drain_reports();
        write_cfg(sndo_pkg::CFG_FAST, 4'd1);
        send_word(sndo_pkg::OP_RESTART, 3'd0, '0, '0, '0, '0);
        repeat (3)
            send_step();
    endtask

    // Dimension 0 at the top of the coordinate range: the step carries its
    // position past 32 bits and it must stay there, finished.
    task automatic test_overflow();
        drain_reports();
        write_cfg(sndo_pkg::CFG_RANK, 4'd1);
        write_cfg(sndo_pkg::CFG_FAST, 4'd0);
        send_word(sndo_pkg::OP_LOAD, 3'd0, 32'hFFFF_FFFE, '1, '1, '1);
        send_word(sndo_pkg::OP_RESTART, 3'd0, '0, '0, '0, '0);
        send_step();
        send_step();
    endtask

    // Eight phases, each with its own register setting, cycling through four idle
    // patterns: none, sender idle, receiver stall, both at once.
    task automatic test_random_phases();
        int p;
        int phase_end;
        for (p = 0; p < 8; p++)
        begin
            drain_reports();
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 52; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 52; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            write_cfg(sndo_pkg::CFG_RANK, RANK_PLAN[p]);
            write_cfg(sndo_pkg::CFG_FAST, {3'($urandom_range(7)), p[0]});
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(3) != 0)
                    walk_hyperslab();
                else
                    repeat ($urandom_range(1, 4))
                        send_noise();
                if ($urandom_range(19) == 0)
                    drain_reports();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    // Randomize the result-side ready once per cycle at the current rate.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (report_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d more %0d offset %h run %h",
                             m_tuser[1:0], m_tuser[2], m_tdata[63:0], m_tdata[95:64]);
            end
            else
            begin
                want = report_q.pop_front();
                if (m_tuser[1:0] !== want.status || m_tuser[2] !== want.more ||
                    m_tdata[63:0] !== want.offset || m_tdata[95:64] !== want.run)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected status %0d more %0d ",
                                  "offset %h run %h, got status %0d more %0d ",
                                  "offset %h run %h"},
                                 want.status, want.more, want.offset, want.run,
                                 m_tuser[1:0], m_tuser[2], m_tdata[63:0], m_tdata[95:64]);
                end
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------
    initial
    begin
        for (int d = 0; d < sndo_pkg::MAX_DIMS; d++)
            slab_pos[d] = '0;
        rank_reg = 4'd1;
        fast_reg = 1'b0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_descriptor_loads();
        test_directed_walk();
        test_overflow();
        test_random_phases();

        // let the last words drain, then allow for anything late or extra
        drain_reports();
        stall_pct = 0;
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && report_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
